>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked immediate-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dpss_pkg.sv
// ----------------------------------------------------------------------------
// dpss_pkg
// Types, codes and reset values shared by the dual PWM shape sequencer.
// ----------------------------------------------------------------------------
package dpss_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_WAIT  = 3'd1,
    ST_START = 3'd2,
    ST_RUN   = 3'd3,
    ST_END   = 3'd4
  } stage_t;

  localparam logic [1:0] FUNC_PASS  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [1:0] SHAPE_FIG8   = 2'd1;
  localparam logic [1:0] SHAPE_TRI    = 2'd2;

  localparam logic [2:0] REG_WAIT_TICKS   = 3'd0;
  localparam logic [2:0] REG_PERIOD_TICKS = 3'd1;
  localparam logic [2:0] REG_CIRCLE_TRAV  = 3'd2;
  localparam logic [2:0] REG_FIG8_TRAV    = 3'd3;
  localparam logic [2:0] REG_TRI_TRAV     = 3'd4;
  localparam logic [2:0] REG_CIRCLE_DUTY  = 3'd5;
  localparam logic [2:0] REG_FIG8_DUTY    = 3'd6;
  localparam logic [2:0] REG_TRI_DUTY     = 3'd7;

  localparam logic [3:0] FIG8_PHASES = 4'd4;
  localparam logic [3:0] TRI_PHASES  = 4'd12;

  localparam logic [15:0] RST_WAIT_TICKS   = 16'd50;
  localparam logic [7:0]  RST_PERIOD_TICKS = 8'd10;
  localparam logic [14:0] RST_CIRCLE_TRAV  = 15'd20;
  localparam logic [15:0] RST_FIG8_TRAV    = 16'd20;
  localparam logic [31:0] RST_TRI_TRAV     = 32'd2621465;
  localparam logic [15:0] RST_CIRCLE_DUTY  = 16'd1802;
  localparam logic [31:0] RST_FIG8_DUTY    = 32'd117574151;
  localparam logic [31:0] RST_TRI_DUTY     = 32'd151651082;

endpackage

>>> sv/dual_pwm_shape_sequencer_top.sv
// ----------------------------------------------------------------------------
// dual_pwm_shape_sequencer_top
// Two-wheel software PWM sequencer running circle, figure-8 and triangle.
// ----------------------------------------------------------------------------
// One item is taken per clock unless stalled and gives its result next cycle. The whole
// sequencer update (stage, counters, phase, drive pins) is one combinational
// pass from the accepted item and the held state into the state registers and
// the result register; a new item is taken whenever the result register is
// empty or its result is being taken in the same cycle, so a stalled output
// holds the input for as long as it stalls. Configuration writes take effect
// at the edge they are written and have no read-back.
`include "assert_macros.svh"

module dual_pwm_shape_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [1:0]  shape,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        right_drive,
  output logic        left_drive,
  output logic        busy_res,
  output logic [2:0]  stage,
  output logic [3:0]  phase_now,
  output logic        done_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dpss_pkg::*;

  logic [15:0] wait_ticks;
  logic [7:0]  period_ticks;
  logic [14:0] circ_periods;
  logic [15:0] fig8_periods;
  logic [31:0] tri_travel_pair;
  logic [15:0] circle_duty_pair;
  logic [31:0] fig8_duty_word;
  logic [31:0] tri_duty_word;

  stage_t      stage_reg, stage_next;
  logic [1:0]  active_shape, active_shape_next;
  logic        tick_pending, tick_pending_next;
  logic [15:0] period_count, period_count_next;
  logic [15:0] delay_count, delay_count_next;
  logic [15:0] segment_done, segment_done_next;
  logic [15:0] right_duty_count, right_duty_count_next;
  logic [15:0] left_duty_count, left_duty_count_next;
  logic [3:0]  phase_reg, phase_reg_next;
  logic        drv_r, drv_r_next;
  logic        drv_l, drv_l_next;
  logic        done_next;

  logic        accept;
  logic        odd;
  logic [15:0] duty_sel;
  logic [7:0]  rlim, llim;
  logic [15:0] travel;
  logic [3:0]  phases;
  logic        phased;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks       <= RST_WAIT_TICKS;
      period_ticks     <= RST_PERIOD_TICKS;
      circ_periods     <= RST_CIRCLE_TRAV;
      fig8_periods     <= RST_FIG8_TRAV;
      tri_travel_pair  <= RST_TRI_TRAV;
      circle_duty_pair <= RST_CIRCLE_DUTY;
      fig8_duty_word   <= RST_FIG8_DUTY;
      tri_duty_word    <= RST_TRI_DUTY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAIT_TICKS:   wait_ticks       <= cfg_data[15:0];
        REG_PERIOD_TICKS: period_ticks     <= cfg_data[7:0];
        REG_CIRCLE_TRAV:  circ_periods     <= cfg_data[14:0];
        REG_FIG8_TRAV:    fig8_periods     <= cfg_data[15:0];
        REG_TRI_TRAV:     tri_travel_pair  <= cfg_data;
        REG_CIRCLE_DUTY:  circle_duty_pair <= cfg_data[15:0];
        REG_FIG8_DUTY:    fig8_duty_word   <= cfg_data;
        REG_TRI_DUTY:     tri_duty_word    <= cfg_data;
        default: ;
      endcase
    end
  end

  // shape-dependent limits and travel
  always_comb begin
    odd      = phase_reg[0];
    duty_sel = circle_duty_pair;
    travel   = {circ_periods, 1'b0};
    phases   = FIG8_PHASES;
    phased   = 1'b0;
    unique case (active_shape)
      SHAPE_FIG8: begin
        duty_sel = odd ? fig8_duty_word[15:0] : fig8_duty_word[31:16];
        travel   = fig8_periods;
        phases   = FIG8_PHASES;
        phased   = 1'b1;
      end
      SHAPE_TRI: begin
        duty_sel = odd ? tri_duty_word[15:0] : tri_duty_word[31:16];
        travel   = odd ? tri_travel_pair[15:0] : tri_travel_pair[31:16];
        phases   = TRI_PHASES;
        phased   = 1'b1;
      end
      default: ;
    endcase
    rlim = duty_sel[15:8];
    llim = duty_sel[7:0];
  end

  // next state
  always_comb begin
    stage_next            = stage_reg;
    active_shape_next     = active_shape;
    tick_pending_next     = tick_pending;
    period_count_next     = period_count;
    delay_count_next      = delay_count;
    segment_done_next     = segment_done;
    right_duty_count_next = right_duty_count;
    left_duty_count_next  = left_duty_count;
    phase_reg_next        = phase_reg;
    drv_r_next            = drv_r;
    drv_l_next            = drv_l;
    done_next             = 1'b0;
    if (func == FUNC_START) begin
      if (stage_reg == ST_IDLE && shape <= SHAPE_TRI) begin
        active_shape_next = shape;
        stage_next        = ST_WAIT;
        delay_count_next  = '0;
      end
    end else if (func == FUNC_PASS || func == FUNC_TICK) begin
      if (func == FUNC_TICK) begin
        tick_pending_next = 1'b1;
        period_count_next = period_count + 16'd1;
      end
      unique case (stage_reg)
        ST_WAIT: begin
          if (tick_pending_next) begin
            tick_pending_next = 1'b0;
            delay_count_next  = delay_count + 16'd1;
            if (delay_count >= wait_ticks) begin
              delay_count_next = '0;
              stage_next       = ST_START;
            end
          end
        end
        ST_START: begin
          period_count_next     = '0;
          right_duty_count_next = '0;
          left_duty_count_next  = '0;
          segment_done_next     = '0;
          phase_reg_next        = '0;
          drv_r_next            = 1'b1;
          drv_l_next            = 1'b1;
          stage_next            = ST_RUN;
        end
        ST_RUN: begin
          if (tick_pending_next && active_shape <= SHAPE_TRI) begin
            tick_pending_next = 1'b0;
            if (phased && phase_reg >= phases) begin
              stage_next = ST_END;
            end else if (segment_done > travel) begin
              if (phased) begin
                segment_done_next     = '0;
                period_count_next     = '0;
                right_duty_count_next = '0;
                left_duty_count_next  = '0;
                phase_reg_next        = phase_reg + 4'd1;
                drv_r_next            = 1'b1;
                drv_l_next            = 1'b1;
              end else begin
                stage_next = ST_END;
              end
            end else begin
              right_duty_count_next = right_duty_count + 16'd1;
              left_duty_count_next  = left_duty_count + 16'd1;
              if (right_duty_count >= {8'd0, rlim}) drv_r_next = 1'b0;
              if (left_duty_count >= {8'd0, llim}) drv_l_next = 1'b0;
              if (period_count_next >= {8'd0, period_ticks}) begin
                period_count_next     = '0;
                right_duty_count_next = '0;
                left_duty_count_next  = '0;
                segment_done_next     = segment_done + 16'd1;
                drv_r_next            = 1'b1;
                drv_l_next            = 1'b1;
              end
            end
          end else if (tick_pending_next) begin
            tick_pending_next = 1'b0;
          end
        end
        ST_END: begin
          drv_r_next = 1'b0;
          drv_l_next = 1'b0;
          stage_next = ST_IDLE;
          done_next  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg        <= ST_IDLE;
      active_shape     <= '0;
      tick_pending     <= 1'b0;
      period_count     <= '0;
      delay_count      <= '0;
      segment_done     <= '0;
      right_duty_count <= '0;
      left_duty_count  <= '0;
      phase_reg        <= '0;
      drv_r            <= 1'b0;
      drv_l            <= 1'b0;
    end else if (accept) begin
      stage_reg        <= stage_next;
      active_shape     <= active_shape_next;
      tick_pending     <= tick_pending_next;
      period_count     <= period_count_next;
      delay_count      <= delay_count_next;
      segment_done     <= segment_done_next;
      right_duty_count <= right_duty_count_next;
      left_duty_count  <= left_duty_count_next;
      phase_reg        <= phase_reg_next;
      drv_r            <= drv_r_next;
      drv_l            <= drv_l_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      right_drive <= drv_r_next;
      left_drive  <= drv_l_next;
      busy_res    <= (stage_next != ST_IDLE);
      stage       <= stage_next;
      phase_now   <= phase_reg_next;
      done_res    <= done_next;
    end
  end

  `ASSERT_IMPL(a_done_stops, out_valid && done_res, stage == ST_IDLE && !busy_res && !right_drive && !left_drive, "done without stop")
  `ASSERT_NEXT(a_transfer_result, accept, out_valid, "transfer gave no result")
  `ASSERT_NEXT(a_start_taken, accept && func == FUNC_START && stage_reg == ST_IDLE && shape != 2'b11, stage_reg == ST_WAIT, "start not taken")

endmodule
